// File: design/lee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lee_pkg
// Shared types and constants for the line editor: line geometry, byte codes,
// command kinds passed from the front end to the back end, and echo actions.
// ----------------------------------------------------------------------------
package lee_pkg;

    localparam int LINE_LEN = 40;
    localparam int ADDR_W   = $clog2(LINE_LEN);
    localparam int LEN_W    = $clog2(LINE_LEN + 1);

    localparam logic [7:0] BYTE_END    = 8'd4;
    localparam logic [7:0] BYTE_NL     = 8'd10;
    localparam logic [7:0] BYTE_KILL   = 8'd21;
    localparam logic [7:0] BYTE_WERASE = 8'd23;
    localparam logic [7:0] BYTE_SPACE  = 8'd32;
    localparam logic [7:0] BYTE_ERASE  = 8'd127;

    typedef enum logic [2:0] {
        ACT_ECHO = 3'd0,
        ACT_RUB  = 3'd1,
        ACT_NL   = 3'd2,
        ACT_BELL = 3'd3,
        ACT_END  = 3'd4
    } t_act;

    typedef enum logic [2:0] {
        CMD_END    = 3'd0,
        CMD_ERASE  = 3'd1,
        CMD_KILL   = 3'd2,
        CMD_WERASE = 3'd3,
        CMD_NL     = 3'd4,
        CMD_BELL   = 3'd5,
        CMD_PRINT  = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
    } t_cmd;

endpackage

// File: design/line_edit_echo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_edit_echo
// Canonical terminal line editor: stores typed characters and emits echo
// actions (echo, rub out, newline, bell, end of input) for the typed bytes.
// ----------------------------------------------------------------------------
// Timing: a byte's first result goes through the command queue and the output
// register (kill also through S_RUB). The back end takes one single-result
// byte per cycle while the output is free; rub-out runs give one result per
// cycle unless stalled; word erase walks S_WAIT and S_CHK for each examined
// character (one registered RAM read each), re-checking the turn to the word.
// Reset: synchronous, active low; clears line length, queue and output valid.
// ----------------------------------------------------------------------------
module line_edit_echo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // typed byte request
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // echo action request
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] action, [10:3] echo_char, rest zero
    output logic        m_axis_tlast    // last action caused by the typed byte
);

    logic          cmd_valid;
    lee_pkg::t_cmd cmd;
    logic          cmd_pop;

    // Front end: decode each byte and queue it
    lee_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back end: update the line and issue the echo actions
    lee_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast)
    );

endmodule

// File: design/lee_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lee_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/lee_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lee_front
// Accepts typed bytes, decodes each into a command and holds the commands
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module lee_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [7:0]    i_s_tdata,
    output logic          o_cmd_valid,
    output lee_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);

    function automatic lee_pkg::t_kind classify(input logic [7:0] b);
        lee_pkg::t_kind k;
        if (b == lee_pkg::BYTE_END) begin
            k = lee_pkg::CMD_END;
        end else if (b == lee_pkg::BYTE_ERASE) begin
            k = lee_pkg::CMD_ERASE;
        end else if (b == lee_pkg::BYTE_KILL) begin
            k = lee_pkg::CMD_KILL;
        end else if (b == lee_pkg::BYTE_WERASE) begin
            k = lee_pkg::CMD_WERASE;
        end else if (b == lee_pkg::BYTE_NL) begin
            k = lee_pkg::CMD_NL;
        end else if (b < lee_pkg::BYTE_SPACE || b[7]) begin
            k = lee_pkg::CMD_BELL;
        end else begin
            k = lee_pkg::CMD_PRINT;
        end
        return k;
    endfunction

    lee_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          push;
    logic          pop;
    lee_pkg::t_cmd cmd_in;

    assign o_s_tready  = (r_cnt != 2'd2);
    assign push        = i_s_tvalid && o_s_tready;
    assign pop         = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        cmd_in.kind = classify(i_s_tdata);
        cmd_in.ch   = i_s_tdata;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

// File: design/lee_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lee_back
// Carries out queued commands: keeps the line store and length, scans for
// word erase, and drives echo actions through an output register.
// ----------------------------------------------------------------------------
module lee_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  lee_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [15:0]   o_m_tdata,
    output logic          o_m_tlast
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WAIT = 5'b00010,
        S_CHK  = 5'b00100,
        S_RUB  = 5'b01000,
        S_ECHO = 5'b10000
    } t_bstate;

    localparam logic [lee_pkg::LEN_W-1:0] FULL = lee_pkg::LEN_W'(lee_pkg::LINE_LEN);
    localparam logic [lee_pkg::LEN_W-1:0] ONE  = lee_pkg::LEN_W'(1);

    t_bstate                     r_state, n_state;
    logic [lee_pkg::LEN_W-1:0]   r_len, n_len;
    logic [lee_pkg::LEN_W-1:0]   r_scan, n_scan;
    logic [lee_pkg::LEN_W-1:0]   r_cnt, n_cnt;
    logic                        r_want, n_want;
    logic [7:0]                  r_ch, n_ch;
    logic                        r_ovalid, n_ovalid;
    lee_pkg::t_act               r_act;
    logic [7:0]                  r_char;
    logic                        r_last;

    logic                        out_free;
    logic                        e_valid;
    lee_pkg::t_act               e_act;
    logic [7:0]                  e_char;
    logic                        e_last;
    logic                        we;
    logic [lee_pkg::ADDR_W-1:0]  waddr;
    logic [lee_pkg::ADDR_W-1:0]  raddr;
    logic [7:0]                  rdata;
    logic                        is_sp;

    lee_ram #(
        .WIDTH (8),
        .DEPTH (lee_pkg::LINE_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_cmd.ch),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign out_free = !r_ovalid || i_m_tready;
    assign raddr    = (r_scan == '0) ? '0 : lee_pkg::ADDR_W'(r_scan - ONE);
    assign waddr    = (r_len < FULL) ? lee_pkg::ADDR_W'(r_len) : '0;
    assign is_sp    = (rdata == lee_pkg::BYTE_SPACE);

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_scan    = r_scan;
        n_cnt     = r_cnt;
        n_want    = r_want;
        n_ch      = r_ch;
        e_valid   = 1'b0;
        e_act     = lee_pkg::ACT_ECHO;
        e_char    = 8'd0;
        e_last    = 1'b1;
        we        = 1'b0;
        o_cmd_pop = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        lee_pkg::CMD_END: begin
                            e_valid = 1'b1;
                            e_act   = (r_len == '0) ? lee_pkg::ACT_END : lee_pkg::ACT_BELL;
                        end
                        lee_pkg::CMD_ERASE: begin
                            if (r_len != '0) begin
                                e_valid = 1'b1;
                                e_act   = lee_pkg::ACT_RUB;
                                n_len   = r_len - ONE;
                            end
                        end
                        lee_pkg::CMD_KILL: begin
                            if (r_len != '0) begin
                                n_cnt   = r_len;
                                n_len   = '0;
                                n_state = S_RUB;
                            end
                        end
                        lee_pkg::CMD_WERASE: begin
                            n_scan  = r_len;
                            n_want  = 1'b1;
                            n_state = S_WAIT;
                        end
                        lee_pkg::CMD_NL: begin
                            e_valid = 1'b1;
                            e_act   = lee_pkg::ACT_NL;
                            n_len   = '0;
                        end
                        lee_pkg::CMD_PRINT: begin
                            we = 1'b1;
                            e_valid = 1'b1;
                            if (r_len < FULL) begin
                                e_act  = lee_pkg::ACT_ECHO;
                                e_char = i_cmd.ch;
                                n_len  = r_len + ONE;
                            end else begin
                                // full line: newline first, echo follows
                                e_act   = lee_pkg::ACT_NL;
                                e_last  = 1'b0;
                                n_len   = ONE;
                                n_ch    = i_cmd.ch;
                                n_state = S_ECHO;
                            end
                        end
                        default: begin
                            e_valid = 1'b1;
                            e_act   = lee_pkg::ACT_BELL;
                        end
                    endcase
                end
            end
            S_WAIT: begin
                if (r_scan == '0) begin
                    n_cnt   = r_len - r_scan;
                    n_len   = r_scan;
                    n_state = (r_len == r_scan) ? S_IDLE : S_RUB;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (is_sp == r_want) begin
                    n_scan  = r_scan - ONE;
                    n_state = S_WAIT;
                end else if (r_want) begin
                    // trailing spaces done, same entry now checked for the word
                    n_want = 1'b0;
                end else begin
                    n_cnt   = r_len - r_scan;
                    n_len   = r_scan;
                    n_state = (r_len == r_scan) ? S_IDLE : S_RUB;
                end
            end
            S_RUB: begin
                if (out_free) begin
                    e_valid = 1'b1;
                    e_act   = lee_pkg::ACT_RUB;
                    e_last  = (r_cnt == ONE);
                    n_cnt   = r_cnt - ONE;
                    if (r_cnt == ONE) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ECHO: begin
                if (out_free) begin
                    e_valid = 1'b1;
                    e_act   = lee_pkg::ACT_ECHO;
                    e_char  = r_ch;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_ovalid = e_valid ? 1'b1 : (r_ovalid && !i_m_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        r_cnt  <= n_cnt;
        r_want <= n_want;
        r_ch   <= n_ch;
        if (e_valid) begin
            r_act  <= e_act;
            r_char <= e_char;
            r_last <= e_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'd0, r_char, r_act};
    assign o_m_tlast  = r_last;

endmodule

// File: verif/line_edit_echo_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_edit_echo_tb
// Self-checking bench for the canonical line editor. A short table of typed
// bytes covers the edit keys, control bytes, high bytes and the empty-line
// cases. Random typed lines follow, some long enough to wrap, most closed by
// an edit key, end or newline. Every echo action is checked against the table
// or a line-buffer predictor kept inside the bench. Both stream sides idle at
// random, and one long hold-off on the echo side backs the block up.
// ----------------------------------------------------------------------------
module line_edit_echo_tb;

    localparam int  ITEMS        = 420;
    localparam int  CALM_ITEMS   = 50;       // no idling over the last requests
    localparam int  HOLD_AFTER   = 60;       // requests taken before the long hold-off
    localparam int  HOLD_CYCLES  = 200;
    localparam int  DRAIN_CYCLES = 120;      // covers a full word-erase scan
    localparam longint LIMIT     = 1_000_000;

    // How a typed byte is checked: by the predictor, or against a result
    // typed into the table (none, or exactly one).
    typedef enum logic [1:0] {
        BY_MODEL,
        NO_ECHO,
        ONE_ECHO
    } t_check;

    typedef struct packed {
        logic [7:0]    b;
        t_check        how;
        lee_pkg::t_act act;
        logic [7:0]    ch;
    } t_typed;

    typedef struct packed {
        lee_pkg::t_act act;
        logic [7:0]    ch;
        logic          last;
    } t_echo;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // [7:0] in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;     // [2:0] action, [10:3] echo_char, rest zero
    logic        m_axis_tlast;

    line_edit_echo i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Directed table: empty-line edits, the bell range edges, printable
    // extremes, end on a busy line, word erase over trailing spaces, kill.
    t_typed typed_tab [24] = '{
        '{lee_pkg::BYTE_END,    ONE_ECHO, lee_pkg::ACT_END,  8'd0},  // end on empty line
        '{lee_pkg::BYTE_ERASE,  NO_ECHO,  lee_pkg::ACT_ECHO, 8'd0},  // nothing to rub out
        '{lee_pkg::BYTE_KILL,   NO_ECHO,  lee_pkg::ACT_ECHO, 8'd0},
        '{lee_pkg::BYTE_WERASE, NO_ECHO,  lee_pkg::ACT_ECHO, 8'd0},
        '{8'd0,                 ONE_ECHO, lee_pkg::ACT_BELL, 8'd0},
        '{8'd31,                ONE_ECHO, lee_pkg::ACT_BELL, 8'd0},
        '{8'd128,               ONE_ECHO, lee_pkg::ACT_BELL, 8'd0},
        '{8'd255,               ONE_ECHO, lee_pkg::ACT_BELL, 8'd0},
        '{lee_pkg::BYTE_SPACE,  ONE_ECHO, lee_pkg::ACT_ECHO, lee_pkg::BYTE_SPACE},
        '{8'd126,               ONE_ECHO, lee_pkg::ACT_ECHO, 8'd126},
        '{8'h61,                ONE_ECHO, lee_pkg::ACT_ECHO, 8'h61},
        '{lee_pkg::BYTE_END,    ONE_ECHO, lee_pkg::ACT_BELL, 8'd0},  // busy line rings
        '{lee_pkg::BYTE_ERASE,  ONE_ECHO, lee_pkg::ACT_RUB,  8'd0},
        '{8'h62,                BY_MODEL, lee_pkg::ACT_ECHO, 8'd0},
        '{lee_pkg::BYTE_SPACE,  BY_MODEL, lee_pkg::ACT_ECHO, 8'd0},
        '{lee_pkg::BYTE_SPACE,  BY_MODEL, lee_pkg::ACT_ECHO, 8'd0},
        '{lee_pkg::BYTE_WERASE, BY_MODEL, lee_pkg::ACT_ECHO, 8'd0},  // spaces, then word
        '{lee_pkg::BYTE_NL,     ONE_ECHO, lee_pkg::ACT_NL,   8'd0},
        '{lee_pkg::BYTE_KILL,   NO_ECHO,  lee_pkg::ACT_ECHO, 8'd0},
        '{8'h71,                BY_MODEL, lee_pkg::ACT_ECHO, 8'd0},
        '{8'h72,                BY_MODEL, lee_pkg::ACT_ECHO, 8'd0},
        '{lee_pkg::BYTE_KILL,   BY_MODEL, lee_pkg::ACT_ECHO, 8'd0},
        '{8'd9,                 ONE_ECHO, lee_pkg::ACT_BELL, 8'd0},
        '{lee_pkg::BYTE_NL,     ONE_ECHO, lee_pkg::ACT_NL,   8'd0}
    };

    // Line buffer as the bench sees it
    logic [7:0]  line_buf [lee_pkg::LINE_LEN];
    int unsigned line_cnt;

    t_typed offered_q [$];   // one entry per typed-byte request, in order
    t_echo  step_q    [$];   // actions for the byte being predicted
    t_echo  echo_q    [$];   // actions still owed by the block

    int     fail_cnt;
    int     sent_cnt;
    int     taken_cnt;
    int     checked_cnt;
    int     wrap_cnt;
    int     max_burst;
    int     tx_gap_pct;
    int     rx_gap_pct;
    bit     calm;
    longint cycle_cnt;

    // ------------------------------------------------------------------
    // Clock, reset, watchdog
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("%0t: timeout, %0d actions still owed", $time, echo_q.size());
            $display("line_edit_echo_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic t_echo mk_echo(input lee_pkg::t_act a, input logic [7:0] c);
        t_echo e;
        e.act  = a;
        e.ch   = c;
        e.last = 1'b0;
        return e;
    endfunction

    // Apply one typed byte to the line buffer and collect its actions.
    function automatic void predict_line(input logic [7:0] b);
        step_q.delete();
        if (b == lee_pkg::BYTE_END && line_cnt == 0) begin
            step_q.push_back(mk_echo(lee_pkg::ACT_END, 8'd0));
        end else if (b == lee_pkg::BYTE_ERASE) begin
            if (line_cnt > 0) begin
                step_q.push_back(mk_echo(lee_pkg::ACT_RUB, 8'd0));
                line_cnt--;
            end
        end else if (b == lee_pkg::BYTE_KILL) begin
            repeat (line_cnt) step_q.push_back(mk_echo(lee_pkg::ACT_RUB, 8'd0));
            line_cnt = 0;
        end else if (b == lee_pkg::BYTE_WERASE) begin
            // trailing spaces first, then back to the space before the word
            while (line_cnt > 0 && line_buf[line_cnt-1] == lee_pkg::BYTE_SPACE) begin
                step_q.push_back(mk_echo(lee_pkg::ACT_RUB, 8'd0));
                line_cnt--;
            end
            while (line_cnt > 0 && line_buf[line_cnt-1] != lee_pkg::BYTE_SPACE) begin
                step_q.push_back(mk_echo(lee_pkg::ACT_RUB, 8'd0));
                line_cnt--;
            end
        end else if (b == lee_pkg::BYTE_NL) begin
            step_q.push_back(mk_echo(lee_pkg::ACT_NL, 8'd0));
            line_cnt = 0;
        end else if (b < lee_pkg::BYTE_SPACE || b >= 8'd128) begin
            step_q.push_back(mk_echo(lee_pkg::ACT_BELL, 8'd0));
        end else begin
            // full line: wrap onto a fresh line holding this byte
            if (line_cnt >= lee_pkg::LINE_LEN) begin
                step_q.push_back(mk_echo(lee_pkg::ACT_NL, 8'd0));
                line_cnt = 0;
                wrap_cnt++;
            end
            line_buf[line_cnt] = b;
            line_cnt++;
            step_q.push_back(mk_echo(lee_pkg::ACT_ECHO, b));
        end
        if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
        if (step_q.size() > max_burst) max_burst = step_q.size();
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict on each typed-byte request, check each echo request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : mon
        t_typed row;
        t_echo  want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                row = offered_q.pop_front();
                predict_line(s_axis_tdata);
                taken_cnt++;
                case (row.how)
                    BY_MODEL: begin
                        foreach (step_q[k]) echo_q.push_back(step_q[k]);
                    end
                    ONE_ECHO: begin
                        want      = mk_echo(row.act, row.ch);
                        want.last = 1'b1;
                        echo_q.push_back(want);
                    end
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                checked_cnt++;
                if (echo_q.size() == 0) begin
                    fail_cnt++;
                    $display({"%0t: unexpected action, expected none, ",
                              "got act=%0d ch=%02h last=%0d"},
                             $time, m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tlast);
                end else begin
                    want = echo_q.pop_front();
                    if (m_axis_tdata[2:0] !== want.act || m_axis_tdata[10:3] !== want.ch ||
                        m_axis_tlast !== want.last) begin
                        fail_cnt++;
                        $display({"%0t: mismatch, expected act=%0d ch=%02h last=%0d, ",
                                  "got act=%0d ch=%02h last=%0d"},
                                 $time, want.act, want.ch, want.last,
                                 m_axis_tdata[2:0], m_axis_tdata[10:3], m_axis_tlast);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Echo side: random stalls, one long hold-off to fill the block
    // ------------------------------------------------------------------
    initial begin : echo_side
        int  gap;
        bit  held;
        held          = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && taken_cnt >= HOLD_AFTER) begin
                // hold off while the typist keeps going
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 99) < rx_gap_pct) begin
                gap = $urandom_range(1, 11);
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Typing side
    // ------------------------------------------------------------------
    // Offer one typed byte and hold it until the block takes it.
    task automatic type_byte(input t_typed row);
        int gap;
        if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
            gap = $urandom_range(1, 11);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        offered_q.push_back(row);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row.b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_cnt++;
        // alternate busy and quiet stretches on both sides
        if (sent_cnt % 40 == 0) begin
            tx_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
            rx_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
        end
        if (sent_cnt >= ITEMS - CALM_ITEMS) calm = 1'b1;
    endtask

    task automatic type_random(input logic [7:0] b);
        t_typed row;
        row     = '{b, BY_MODEL, lee_pkg::ACT_ECHO, 8'd0};
        type_byte(row);
    endtask

    // One random line: mostly words and spaces with the odd edit or noise
    // byte; long lines stay clean so that they reach the wrap.
    task automatic type_line();
        int         target;
        int         r;
        bit         long_line;
        logic [7:0] b;
        long_line = ($urandom_range(0, 6) == 0);
        target    = long_line ? $urandom_range(38, 46) : $urandom_range(0, 20);
        for (int k = 0; k < target; k++) begin
            r = $urandom_range(0, 99);
            if (r < 75 || (long_line && r < 90)) b = 8'($urandom_range(33, 126));
            else if (r < 88 || long_line)        b = lee_pkg::BYTE_SPACE;
            else if (r < 92)                     b = lee_pkg::BYTE_ERASE;
            else if (r < 95)                     b = lee_pkg::BYTE_WERASE;
            else if (r < 96)                     b = lee_pkg::BYTE_KILL;
            else                                 b = 8'($urandom_range(0, 255));
            type_random(b);
        end
        // close most lines
        r = $urandom_range(0, 99);
        if (r < 40) begin
            type_random(lee_pkg::BYTE_NL);
            if ($urandom_range(0, 4) == 0) type_random(lee_pkg::BYTE_END);
        end else if (r < 60) type_random(lee_pkg::BYTE_KILL);
        else if (r < 80) type_random(lee_pkg::BYTE_WERASE);
        else if (r < 88) type_random(lee_pkg::BYTE_END);
    endtask

    initial begin : typist
        fail_cnt      = 0;
        sent_cnt      = 0;
        taken_cnt     = 0;
        checked_cnt   = 0;
        wrap_cnt      = 0;
        max_burst     = 0;
        tx_gap_pct    = 25;
        rx_gap_pct    = 25;
        calm          = 1'b0;
        cycle_cnt     = 0;
        line_cnt      = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (typed_tab[k]) type_byte(typed_tab[k]);
        while (sent_cnt < ITEMS) type_line();

        s_axis_tvalid <= 1'b0;
        while (echo_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Typed %0d bytes over directed and random lines; %0d echo actions checked.",
                 taken_cnt, checked_cnt);
        $display("Line wraps seen: %0d; longest action run for one byte: %0d.",
                 wrap_cnt, max_burst);
        if (fail_cnt == 0) begin
            $display("line_edit_echo_tb passed");
        end else begin
            $display("line_edit_echo_tb failed");
        end
        $finish;
    end

endmodule

// File: sim.f
design/lee_pkg.sv
design/lee_ram.sv
design/lee_front.sv
design/lee_back.sv
design/line_edit_echo.sv
verif/line_edit_echo_tb.sv
